### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Constants and codes shared by the sequence reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int unsigned DEPTH     = 32;
  localparam int unsigned TAG_WIDTH = 16;
  localparam int unsigned SEQ_WIDTH = 32;

  localparam int unsigned OP_WIDTH     = 2;
  localparam int unsigned STATUS_WIDTH = 3;

  localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_FINISH = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_KILL   = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_RELEASED  = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_DONE      = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_ORDER_ERR = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_KILLED    = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_REJECTED  = 3'd4;

endpackage

### hdl/srb_ram.sv
// ----------------------------------------------------------------------------
// srb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module srb_ram #(
  parameter int unsigned WIDTH = srb_pkg::TAG_WIDTH,
  parameter int unsigned DEPTH = srb_pkg::DEPTH
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/sequence_reorder_buffer_top.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_top
// Reorder buffer by sequence number. Tagged items arrive in any order within
// a window of DEPTH numbers from the expected one and leave strictly in
// ascending order; out-of-window, duplicate and post-halt items are rejected.
// Timing: an item is taken into an input register, then decided once the
// output is free: buffered, or answered with a single result. An in-order
// insert releases its item and the buffered ones that follow in order, from
// the tag RAM, whose single registered read port gives one release per cycle
// while the output is not stalled. Slot valid bits are flip-flops cleared by
// reset, so no clearing pass is needed. Output stall holds the block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sequence_reorder_buffer_top #(
  parameter int unsigned DEPTH     = srb_pkg::DEPTH,
  parameter int unsigned TAG_WIDTH = srb_pkg::TAG_WIDTH,
  parameter int unsigned SEQ_WIDTH = srb_pkg::SEQ_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [srb_pkg::OP_WIDTH-1:0]      operation_i,
  input  logic [SEQ_WIDTH-1:0]              seq_num_i,
  input  logic [TAG_WIDTH-1:0]              task_tag_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [srb_pkg::STATUS_WIDTH-1:0]  status_o,
  output logic [SEQ_WIDTH-1:0]              seq_out_o,
  output logic [TAG_WIDTH-1:0]              tag_out_o,
  output logic                              last_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                         state_q, state_d;
  logic [SEQ_WIDTH-1:0]               expected_q, expected_d;
  logic [IDX_W-1:0]                   head_q, head_d;
  logic [DEPTH-1:0]                   valid_q, valid_d;
  logic [CNT_W-1:0]                   pending_q, pending_d;
  logic                               halted_q, halted_d;

  logic [srb_pkg::OP_WIDTH-1:0]       op_q;
  logic [SEQ_WIDTH-1:0]               seq_q;
  logic [TAG_WIDTH-1:0]               tag_q;

  logic                               out_valid_q, out_valid_d;
  logic [srb_pkg::STATUS_WIDTH-1:0]   status_q, status_d;
  logic [SEQ_WIDTH-1:0]               seq_out_q, seq_out_d;
  logic [TAG_WIDTH-1:0]               tag_out_q, tag_out_d;
  logic                               last_q, last_d;

  logic                               in_acc;
  logic                               out_free;
  logic [SEQ_WIDTH-1:0]               seq_dist;
  logic                               in_window;
  logic [IDX_W:0]                     slot_sum;
  logic [IDX_W-1:0]                   slot;
  logic [IDX_W-1:0]                   head_nx;
  logic                               more;

  logic                               ram_we;
  logic                               ram_re;
  logic [TAG_WIDTH-1:0]               ram_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign seq_dist  = seq_q - expected_q;
  assign in_window = (seq_dist < SEQ_WIDTH'(DEPTH));
  assign slot_sum  = {1'b0, head_q} + {1'b0, seq_dist[IDX_W-1:0]};
  assign slot      = (slot_sum >= (IDX_W+1)'(DEPTH)) ?
                     IDX_W'(slot_sum - (IDX_W+1)'(DEPTH)) : slot_sum[IDX_W-1:0];
  assign head_nx   = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
  assign more      = valid_q[head_nx];

  always_comb begin
    state_d     = state_q;
    expected_d  = expected_q;
    head_d      = head_q;
    valid_d     = valid_q;
    pending_d   = pending_q;
    halted_d    = halted_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    seq_out_d   = seq_out_q;
    tag_out_d   = tag_out_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = srb_pkg::ST_REJECTED;
          seq_out_d   = '0;
          tag_out_d   = '0;
          last_d      = 1'b1;
          priority if (halted_q) begin
            status_d = srb_pkg::ST_REJECTED;
          end else if (op_q == srb_pkg::OP_FINISH) begin
            halted_d = 1'b1;
            status_d = (pending_q == '0) ? srb_pkg::ST_DONE : srb_pkg::ST_ORDER_ERR;
          end else if (op_q == srb_pkg::OP_KILL) begin
            halted_d = 1'b1;
            status_d = srb_pkg::ST_KILLED;
          end else if (op_q != srb_pkg::OP_INSERT || !in_window || valid_q[slot]) begin
            status_d = srb_pkg::ST_REJECTED;
          end else if (seq_dist != '0) begin
            out_valid_d   = out_valid_q && out_stall_i;
            ram_we        = 1'b1;
            valid_d[slot] = 1'b1;
            pending_d     = pending_q + CNT_W'(1);
          end else begin
            status_d   = srb_pkg::ST_RELEASED;
            seq_out_d  = seq_q;
            tag_out_d  = tag_q;
            last_d     = !more;
            expected_d = expected_q + SEQ_WIDTH'(1);
            head_d     = head_nx;
            ram_re     = more;
            state_d    = more ? S_DRAIN : S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          status_d        = srb_pkg::ST_RELEASED;
          seq_out_d       = expected_q;
          tag_out_d       = ram_rdata;
          last_d          = !more;
          valid_d[head_q] = 1'b0;
          pending_d       = pending_q - CNT_W'(1);
          expected_d      = expected_q + SEQ_WIDTH'(1);
          head_d          = head_nx;
          ram_re          = more;
          state_d         = more ? S_DRAIN : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      expected_q  <= '0;
      head_q      <= '0;
      valid_q     <= '0;
      pending_q   <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      expected_q  <= expected_d;
      head_q      <= head_d;
      valid_q     <= valid_d;
      pending_q   <= pending_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= operation_i;
      seq_q <= seq_num_i;
      tag_q <= task_tag_i;
    end
    status_q  <= status_d;
    seq_out_q <= seq_out_d;
    tag_out_q <= tag_out_d;
    last_q    <= last_d;
  end

  srb_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (slot),
    .wr_data_i (tag_q),
    .rd_en_i   (ram_re),
    .rd_addr_i (head_nx),
    .rd_data_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign seq_out_o   = seq_out_q;
  assign tag_out_o   = tag_out_q;
  assign last_o      = last_q;

  `ASSERT_RST(a_pending_matches_valid, clk_i, rst_ni, (pending_q == CNT_W'($countones(valid_q))), "pending count differs from number of valid slots")
  `ASSERT_RST(a_halt_sticky, clk_i, rst_ni, halted_q |=> halted_q, "halt was cleared")
  `ASSERT_RST(a_drain_head_valid, clk_i, rst_ni, (state_q == S_DRAIN) |-> valid_q[head_q], "draining an empty head slot")

endmodule
